// ===== rtl/bbuvq_pkg.sv =====
// ----------------------------------------------------------------------------
// bbuvq_pkg
// Shared widths, codes and interface types of the bounding-box quantizer.
// ----------------------------------------------------------------------------
package bbuvq_pkg;

    // Field and datapath widths
    localparam int COORD_W  = 32;   // Q16.16 coordinate
    localparam int DIFF_W   = 33;   // coordinate difference / box extent
    localparam int MVAL_W   = 16;   // 2^bits - 1
    localparam int PROD_W   = 50;   // difference times 2^bits - 1
    localparam int NUM_W    = 51;   // rounding numerator
    localparam int MAG_W    = 50;   // numerator magnitude
    localparam int DEN_W    = 34;   // twice the range
    localparam int QUO_W    = 32;   // quotient bits resolved by the divider
    localparam int DIV_CNT_W = $clog2(QUO_W);

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int QBITS_W = 5;
    localparam int CCOUNT_W = 2;

    // Register indexes (word address)
    localparam logic REG_QUANT_BITS = 1'b0;
    localparam logic REG_COMP_COUNT = 1'b1;

    // Reset values of the registers
    localparam logic [QBITS_W-1:0]  QBITS_RESET  = 5'd12;
    localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 2'd3;

    // Request codes
    localparam logic REQ_MEASURE  = 1'b0;
    localparam logic REQ_QUANTIZE = 1'b1;

    // Bit depth limits and component count codes
    localparam logic [QBITS_W-1:0]  MIN_QUANT_BITS = 5'd7;
    localparam logic [QBITS_W-1:0]  MAX_QUANT_BITS = 5'd16;
    localparam logic [CCOUNT_W-1:0] COMP_COUNT_TWO = 2'd2;

    // Saturation bounds of a result field
    localparam logic [COORD_W-1:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] INT_MIN = 32'h8000_0000;

    // Divider control and status
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;      // quotient does not fit in QUO_W bits
        logic rem_nz;   // remainder non-zero
    } div_sts_t;

endpackage

// ===== rtl/bbuvq_div.sv =====
// ----------------------------------------------------------------------------
// bbuvq_div
// Restoring divider, one quotient bit a cycle, with early overflow detection.
// ----------------------------------------------------------------------------
module bbuvq_div
    import bbuvq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  div_ctl_t         ctl,
    input  logic [MAG_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [QUO_W-1:0] quotient,
    output div_sts_t         sts
);

    localparam int HI_W = MAG_W - QUO_W;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 ovf_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     low_reg;
    logic [QUO_W-1:0]     q_reg;

    logic [DEN_W-1:0] rem_init;
    logic             ovf_init;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_diff;
    logic             trial_ge;
    logic [DEN_W-1:0] rem_next;
    logic             last_iter;

    // Upper dividend bits form the first partial remainder; if they already
    // reach the divisor the quotient needs more than QUO_W bits
    assign rem_init = {{(DEN_W-HI_W){1'b0}}, dividend[MAG_W-1:QUO_W]};
    assign ovf_init = rem_init >= divisor;

    // Shared subtract and compare
    assign trial      = {rem_reg, low_reg[QUO_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign trial_ge   = trial >= {1'b0, den_reg};
    assign rem_next   = trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
    assign last_iter  = cnt_reg == DIV_CNT_W'(QUO_W - 1);

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                cnt_reg  <= '0;
                busy_reg <= !ovf_init;
                done_reg <= ovf_init;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_iter) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            den_reg <= divisor;
            rem_reg <= rem_init;
            low_reg <= dividend[QUO_W-1:0];
            ovf_reg <= ovf_init;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            q_reg   <= {q_reg[QUO_W-2:0], trial_ge};
        end
    end

    assign quotient   = q_reg;
    assign sts.busy   = busy_reg;
    assign sts.done   = done_reg;
    assign sts.ovf    = ovf_reg;
    assign sts.rem_nz = |rem_reg;

endmodule

// ===== rtl/bbuvq_top.sv =====
// ----------------------------------------------------------------------------
// bbox_uniform_vertex_quantizer_top
// Bounding-box uniform quantizer for 2 or 3 component Q16.16 vectors.
// ----------------------------------------------------------------------------
// Measure request: folded into the box at acceptance, one a cycle while idle, no result.
// Pass-through quantize (bit depth below 7): result goes through the done state to the output register.
// Quantize: each component runs through the shared one-bit-a-cycle divider,
// skipped when the range is zero; the next request is taken in the same cycle
// the result appears, which then waits in the output register.
// Reset (aresetn low, synchronous) clears the box, bits = 12, components = 3.
// ----------------------------------------------------------------------------
module bbox_uniform_vertex_quantizer_top
    import bbuvq_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    // request channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic                      s_start_box,
    input  logic signed [COORD_W-1:0] s_coord_x,
    input  logic signed [COORD_W-1:0] s_coord_y,
    input  logic signed [COORD_W-1:0] s_coord_z,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_out_x,
    output logic signed [COORD_W-1:0] m_out_y,
    output logic signed [COORD_W-1:0] m_out_z
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RNG1 = 4'd1;
    localparam logic [3:0] ST_RNG2 = 4'd2;
    localparam logic [3:0] ST_DIFF = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_NUM  = 4'd5;
    localparam logic [3:0] ST_ABS  = 4'd6;
    localparam logic [3:0] ST_DIVS = 4'd7;
    localparam logic [3:0] ST_DIVW = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;

    logic [QBITS_W-1:0]  qbits_reg;
    logic [CCOUNT_W-1:0] ccount_reg;

    logic signed [COORD_W-1:0] box_min_reg [3];
    logic signed [COORD_W-1:0] box_max_reg [3];
    logic signed [COORD_W-1:0] c_reg [3];
    logic signed [DIFF_W-1:0]  ext_reg [3];
    logic signed [DIFF_W-1:0]  range_reg;
    logic [MVAL_W-1:0]         mval_reg;
    logic [1:0]                comp_reg;
    logic signed [DIFF_W-1:0]  d_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic [COORD_W-1:0]        res_reg [3];

    logic                      m_valid_reg;
    logic [COORD_W-1:0]        m_x_reg;
    logic [COORD_W-1:0]        m_y_reg;
    logic [COORD_W-1:0]        m_z_reg;

    logic                      cfg_wr;
    logic                      s_fire;
    logic                      two_comp;
    logic [1:0]                last_comp;
    logic                      low_depth;
    logic [QBITS_W-1:0]        bits_sat;
    logic signed [COORD_W-1:0] s_coord [3];
    logic signed [COORD_W-1:0] c_sel;
    logic signed [COORD_W-1:0] min_sel;
    logic signed [DIFF_W-1:0]  range_calc;
    logic signed [NUM_W-1:0]   num_neg;
    logic [COORD_W:0]          neg_mag;
    logic [COORD_W:0]          neg_res;
    logic [COORD_W-1:0]        fin_val;
    logic                      out_free;

    div_ctl_t                  div_ctl;
    div_sts_t                  div_sts;
    logic [QUO_W-1:0]          div_q;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qbits_reg  <= QBITS_RESET;
            ccount_reg <= CCOUNT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_QUANT_BITS: qbits_reg  <= pwdata[QBITS_W-1:0];
                REG_COMP_COUNT: ccount_reg <= pwdata[CCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_QUANT_BITS: prdata = {{(DATA_W-QBITS_W){1'b0}}, qbits_reg};
            REG_COMP_COUNT: prdata = {{(DATA_W-CCOUNT_W){1'b0}}, ccount_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Common decode
    // ------------------------------------------------------------------------
    assign s_ready   = state_reg == ST_IDLE;
    assign s_fire    = s_valid && s_ready;
    assign two_comp  = ccount_reg == COMP_COUNT_TWO;
    assign last_comp = two_comp ? 2'd1 : 2'd2;
    assign low_depth = qbits_reg < MIN_QUANT_BITS;
    assign bits_sat  = (qbits_reg > MAX_QUANT_BITS) ? MAX_QUANT_BITS : qbits_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign s_coord[0] = s_coord_x;
    assign s_coord[1] = s_coord_y;
    assign s_coord[2] = s_coord_z;

    assign c_sel   = c_reg[comp_reg];
    assign min_sel = box_min_reg[comp_reg];

    // Largest extent over the active axes, never below zero
    always_comb begin
        range_calc = '0;
        if (ext_reg[0] > range_calc) range_calc = ext_reg[0];
        if (ext_reg[1] > range_calc) range_calc = ext_reg[1];
        if (!two_comp && (ext_reg[2] > range_calc)) range_calc = ext_reg[2];
    end

    assign num_neg = -num_reg;

    // Floor of the signed ratio, saturated to the result field
    assign neg_mag = {1'b0, div_q} + {{COORD_W{1'b0}}, div_sts.rem_nz};
    assign neg_res = -neg_mag;
    always_comb begin
        if (div_sts.ovf) begin
            fin_val = neg_reg ? INT_MIN : INT_MAX;
        end else if (!neg_reg) begin
            fin_val = div_q[QUO_W-1] ? INT_MAX : div_q;
        end else if (neg_mag > {1'b0, INT_MIN}) begin
            fin_val = INT_MIN;
        end else begin
            fin_val = neg_res[COORD_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_req_type == REQ_QUANTIZE)) begin
                    state_next = low_depth ? ST_DONE : ST_RNG1;
                end
            end
            ST_RNG1: state_next = ST_RNG2;
            ST_RNG2: state_next = (range_calc <= 0) ? ST_DONE : ST_DIFF;
            ST_DIFF: state_next = ST_MUL;
            ST_MUL:  state_next = ST_NUM;
            ST_NUM:  state_next = ST_ABS;
            ST_ABS:  state_next = ST_DIVS;
            ST_DIVS: state_next = ST_DIVW;
            ST_DIVW: begin
                if (div_sts.done) state_next = ST_FIN;
            end
            ST_FIN:  state_next = (comp_reg == last_comp) ? ST_DONE : ST_DIFF;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------------
    // Bounding box, updated on an accepted measure request
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                box_min_reg[i] <= '0;
                box_max_reg[i] <= '0;
            end
        end else if (s_fire && (s_req_type == REQ_MEASURE)) begin
            for (int i = 0; i < 3; i++) begin
                if ((i < 2) || !two_comp) begin
                    if (s_start_box) begin
                        box_min_reg[i] <= s_coord[i];
                        box_max_reg[i] <= s_coord[i];
                    end else begin
                        if (s_coord[i] < box_min_reg[i]) box_min_reg[i] <= s_coord[i];
                        if (s_coord[i] > box_max_reg[i]) box_max_reg[i] <= s_coord[i];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Quantize datapath
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_req_type == REQ_QUANTIZE)) begin
                    for (int i = 0; i < 3; i++) c_reg[i] <= s_coord[i];
                    // pass-through result
                    res_reg[0] <= s_coord_x;
                    res_reg[1] <= s_coord_y;
                    res_reg[2] <= two_comp ? '0 : s_coord_z;
                end
            end
            ST_RNG1: begin
                for (int i = 0; i < 3; i++) begin
                    ext_reg[i] <= DIFF_W'(box_max_reg[i]) - DIFF_W'(box_min_reg[i]);
                    res_reg[i] <= '0;
                end
                mval_reg <= MVAL_W'((17'd1 << bits_sat) - 17'd1);
                comp_reg <= 2'd0;
            end
            ST_RNG2: range_reg <= range_calc;
            ST_DIFF: d_reg <= DIFF_W'(c_sel) - DIFF_W'(min_sel);
            ST_MUL:  prod_reg <= PROD_W'(d_reg) * PROD_W'($signed({1'b0, mval_reg}));
            ST_NUM:  num_reg <= {prod_reg, 1'b0} + NUM_W'(range_reg);
            ST_ABS: begin
                neg_reg <= num_reg[NUM_W-1];
                mag_reg <= num_reg[NUM_W-1] ? num_neg[MAG_W-1:0] : num_reg[MAG_W-1:0];
            end
            ST_FIN: begin
                res_reg[comp_reg] <= fin_val;
                comp_reg          <= comp_reg + 2'd1;
            end
            default: ;
        endcase
    end

    // Shared divider: magnitude of the numerator over twice the range
    assign div_ctl.start = state_reg == ST_DIVS;

    bbuvq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (mag_reg),
        .divisor  ({range_reg[DIFF_W-1:0], 1'b0}),
        .quotient (div_q),
        .sts      (div_sts)
    );

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            m_x_reg <= res_reg[0];
            m_y_reg <= res_reg[1];
            m_z_reg <= res_reg[2];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_x = m_x_reg;
    assign m_out_y = m_y_reg;
    assign m_out_z = m_z_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_ctl.start |-> !div_sts.busy)
        else $error("divider started while busy");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_sts.done |-> (state_reg == ST_DIVW))
        else $error("divider finished outside its wait state");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result presented without a finished request");

    a_last_comp_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FIN) && (comp_reg == last_comp)) |=> (state_reg == ST_DONE))
        else $error("sequencer ran past the last component");

endmodule

// ===== sim/bbox_uniform_vertex_quantizer_top_tb.sv =====
// ----------------------------------------------------------------------------
// bbox_uniform_vertex_quantizer_top_tb
// Self-checking bench for the bounding-box uniform vertex quantizer. Measure
// and quantize requests are driven over the request channel, the box and the
// expected quantized vertices are tracked alongside, and every result on the
// result channel is compared against the oldest expected vertex. Bit depth
// and component count are changed over the APB port between phases, under
// varied sender and receiver idling, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module bbox_uniform_vertex_quantizer_top_tb;
    import bbuvq_pkg::*;

    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 90;
    localparam int SETTLE_CYCLES = 150;   // longer than one 3-component quantize
    localparam int HOLD_CYCLES  = 600;
    localparam longint LIM_HI   = 64'sd2147483647;
    localparam longint LIM_LO   = -64'sd2147483648;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } vertex_t;

    // ------------------------------------------------------------------------
    // Box tracker and store of expected quantized vertices
    // ------------------------------------------------------------------------
    class quantized_vertex_board;
        logic [QBITS_W-1:0]  qbits;
        logic [CCOUNT_W-1:0] ccount;
        longint              lo_corner[3];
        longint              hi_corner[3];
        vertex_t             pending_vertices[$];
        int                  errors;
        int                  n_requests;
        int                  n_vertices;

        function new();
            qbits  = QBITS_RESET;
            ccount = CCOUNT_RESET;
            for (int i = 0; i < 3; i++) begin
                lo_corner[i] = 0;
                hi_corner[i] = 0;
            end
            errors = 0;
            n_requests = 0;
            n_vertices = 0;
        endfunction

        function void set_register(logic idx, logic [DATA_W-1:0] value);
            if (idx == REG_QUANT_BITS)
                qbits = value[QBITS_W-1:0];
            else
                ccount = value[CCOUNT_W-1:0];
        endfunction

        function logic [COORD_W-1:0] clamp32(longint v);
            if (v > LIM_HI)
                return INT_MAX;
            if (v < LIM_LO)
                return INT_MIN;
            return v[COORD_W-1:0];
        endfunction

        // Fold a measure into the box, or work out the quantized vertex
        function void note_request(logic rt, logic st, logic [COORD_W-1:0] cx,
                                   logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cz);
            longint  c[3];
            longint  q[3];
            longint  m;
            longint  span;
            longint  num;
            longint  den;
            int      n;
            int      bits;
            vertex_t v;
            c[0] = $signed(cx);
            c[1] = $signed(cy);
            c[2] = $signed(cz);
            q[0] = 0;
            q[1] = 0;
            q[2] = 0;
            n = (ccount == COMP_COUNT_TWO) ? 2 : 3;
            n_requests++;
            if (rt == REQ_MEASURE) begin
                for (int i = 0; i < n; i++) begin
                    if (st) begin
                        lo_corner[i] = c[i];
                        hi_corner[i] = c[i];
                    end else begin
                        if (c[i] < lo_corner[i]) lo_corner[i] = c[i];
                        if (c[i] > hi_corner[i]) hi_corner[i] = c[i];
                    end
                end
                return;
            end
            if (qbits < MIN_QUANT_BITS) begin
                for (int i = 0; i < n; i++)
                    q[i] = c[i];
            end else begin
                bits = (qbits > MAX_QUANT_BITS) ? int'(MAX_QUANT_BITS) : int'(qbits);
                m = (longint'(1) << bits) - 1;
                span = 0;
                for (int i = 0; i < n; i++)
                    if (hi_corner[i] - lo_corner[i] > span)
                        span = hi_corner[i] - lo_corner[i];
                for (int i = 0; i < n; i++) begin
                    if (span > 0) begin
                        // round half up, floored towards minus infinity
                        num = 2 * (c[i] - lo_corner[i]) * m + span;
                        den = 2 * span;
                        q[i] = num / den;
                        if ((num % den) != 0 && num < 0)
                            q[i] = q[i] - 1;
                    end
                end
            end
            v.x = clamp32(q[0]);
            v.y = clamp32(q[1]);
            v.z = clamp32(q[2]);
            pending_vertices.push_back(v);
        endfunction

        // Compare one delivered vertex with the oldest expectation
        function void check_vertex(logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy,
                                   logic [COORD_W-1:0] oz);
            vertex_t v;
            n_vertices++;
            if (pending_vertices.size() == 0) begin
                errors++;
                $display("%0t: unexpected vertex x=%h y=%h z=%h", $time, ox, oy, oz);
                return;
            end
            v = pending_vertices.pop_front();
            if (ox !== v.x) begin
                errors++;
                $display("%0t: out_x mismatch expected %h actual %h", $time, v.x, ox);
            end
            if (oy !== v.y) begin
                errors++;
                $display("%0t: out_y mismatch expected %h actual %h", $time, v.y, oy);
            end
            if (oz !== v.z) begin
                errors++;
                $display("%0t: out_z mismatch expected %h actual %h", $time, v.z, oz);
            end
        endfunction

        function int pending();
            return pending_vertices.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_req_type = 1'b0;
    logic                      s_start_box = 1'b0;
    logic signed [COORD_W-1:0] s_coord_x = '0;
    logic signed [COORD_W-1:0] s_coord_y = '0;
    logic signed [COORD_W-1:0] s_coord_z = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [COORD_W-1:0] m_out_x;
    logic signed [COORD_W-1:0] m_out_y;
    logic signed [COORD_W-1:0] m_out_z;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    quantized_vertex_board board;

    bbox_uniform_vertex_quantizer_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_start_box (s_start_box),
        .s_coord_x   (s_coord_x),
        .s_coord_y   (s_coord_y),
        .s_coord_z   (s_coord_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_z     (m_out_z)
    );

    // Clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #1000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_vertex(m_out_x, m_out_y, m_out_z);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_request(logic rt, logic st, logic [COORD_W-1:0] cx,
                                logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cz);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_req_type  <= rt;
        s_start_box <= st;
        s_coord_x   <= cx;
        s_coord_y   <= cy;
        s_coord_z   <= cz;
        do @(posedge aclk); while (!s_ready);
        board.note_request(rt, st, cx, cy, cz);
    endtask

    task automatic write_reg(logic idx, logic [DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register(idx, value);
    endtask

    // Wait for every expected vertex, then let any trailing work finish
    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default:   begin send_idle_pct = 27; recv_stall_pct = 27; end
        endcase
    endtask

    // Box-shaped random stimulus: measure runs followed by quantize runs, mixed with single noise requests
    task automatic random_phase(int count);
        logic [COORD_W-1:0] base[3];
        logic [COORD_W-1:0] mask[3];
        logic [COORD_W-1:0] c[3];
        int                 sent;
        int                 runs;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 80) begin
                for (int a = 0; a < 3; a++) begin
                    base[a] = $urandom;
                    mask[a] = 32'hFFFF_FFFF >> $urandom_range(31);
                    c[a] = base[a] + ($urandom & mask[a]);
                end
                send_request(REQ_MEASURE, 1'b1, c[0], c[1], c[2]);
                runs = $urandom_range(1, 6);
                for (int k = 0; k < runs; k++) begin
                    for (int a = 0; a < 3; a++)
                        c[a] = base[a] + ($urandom & mask[a]);
                    send_request(REQ_MEASURE, 1'b0, c[0], c[1], c[2]);
                end
                sent += runs + 1;
                runs = $urandom_range(1, 6);
                for (int k = 0; k < runs; k++) begin
                    for (int a = 0; a < 3; a++)
                        c[a] = ($urandom_range(7) == 0) ? $urandom
                                                        : base[a] + ($urandom & mask[a]);
                    send_request(REQ_QUANTIZE, 1'($urandom_range(1)), c[0], c[1], c[2]);
                end
                sent += runs;
            end else begin
                // noise: any request type and flag, any coordinates
                send_request(1'($urandom_range(1)), 1'($urandom_range(1)),
                             $urandom, $urandom, $urandom);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int qb_tab[PHASES] = '{12, 16, 7, 6, 0, 31, 20, 8, 16, 13};
        int cc_tab[PHASES] = '{3, 2, 3, 2, 0, 1, 2, 3, 2, 3};
        board = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset box: zero range, then a fold into the zero box
        send_request(REQ_QUANTIZE, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        send_request(REQ_MEASURE, 1'b0, 32'hFFFB_0000, 32'h0003_0000, 32'h0000_0064);
        send_request(REQ_QUANTIZE, 1'b0, 32'h0, 32'h0, 32'h0);
        // Widest possible box, quantize at its corners and near its centre
        send_request(REQ_MEASURE, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_request(REQ_MEASURE, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(REQ_QUANTIZE, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_request(REQ_QUANTIZE, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(REQ_QUANTIZE, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'h1);
        settle();
        write_reg(REG_QUANT_BITS, 32'd16);
        write_reg(REG_COMP_COUNT, 32'd3);
        send_request(REQ_QUANTIZE, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000);
        settle();
        // Pass-through depth; the box still follows measures
        write_reg(REG_QUANT_BITS, 32'd6);
        send_request(REQ_QUANTIZE, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hDEAD_BEEF);
        send_request(REQ_MEASURE, 1'b1, 32'h0, 32'h0, 32'h0);
        send_request(REQ_MEASURE, 1'b0, 32'h0001_0000, 32'h0000_8000, 32'h0000_4000);
        settle();
        // Components far outside a small box saturate both ways
        write_reg(REG_QUANT_BITS, 32'd12);
        send_request(REQ_QUANTIZE, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        send_request(REQ_QUANTIZE, 1'b0, 32'h0000_8000, 32'h0000_4000, 32'h0000_2000);
        settle();
        // Two components: z neither folded nor used, out_z forced to zero
        write_reg(REG_COMP_COUNT, 32'd2);
        send_request(REQ_MEASURE, 1'b1, 32'h0002_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
        send_request(REQ_MEASURE, 1'b0, 32'h0005_0000, 32'h0001_0000, 32'h8000_0000);
        send_request(REQ_QUANTIZE, 1'b0, 32'h0003_0000, 32'h0, 32'h1234_5678);
        send_request(REQ_MEASURE, 1'b1, 32'h5, 32'h5, 32'h9);
        send_request(REQ_QUANTIZE, 1'b0, 32'h5, 32'h5, 32'h64);
        settle();

        // Random phases over a spread of settings and idling patterns
        for (int p = 0; p < PHASES; p++) begin
            write_reg(REG_QUANT_BITS, qb_tab[p]);
            write_reg(REG_COMP_COUNT, cc_tab[p]);
            set_idling(idle_mode_t'(p % 4));
            if (p == 0) begin
                // receiver held off while quantize requests keep coming
                hold_left = HOLD_CYCLES;
                for (int k = 0; k < 12; k++)
                    send_request(REQ_QUANTIZE, 1'b0, $urandom, $urandom, $urandom);
            end
            random_phase(PHASE_ITEMS);
            settle();
        end

        $display("Covered %0d requests and %0d vertices over %0d settings,",
                 board.n_requests, board.n_vertices, PHASES + 4);
        $display("with pass-through, saturation, zero range and a long output stall.");
        if (board.errors == 0 && board.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
